// File: hdl/bwe_pkg.sv
// Package with shared types, constants and the sequencer state type for the byte window entropy block.
package bwe_pkg;

  // Fixed sizes of the histogram and of the result fields.
  localparam int NBINS     = 256;
  localparam int BIN_W     = 8;
  localparam int Q_W       = 17;
  localparam int CNT_OUT_W = 21;
  localparam int Q_SHIFT   = 16;
  // Log mantissa is Q1.30, which takes 31 bits.
  localparam int MANT_W    = 31;

  localparam logic [Q_W-1:0] Q_ONE = 17'd65536;

  // Status codes of a result.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_SINGLE = 2'd1;
  localparam logic [1:0] STAT_LONG   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [16:0] entropy_q16;
    logic [20:0] byte_count;
    logic [1:0]  status;
  } result_t;

  // Head of the item queue as the back end sees it.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } q_head_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_WK_RD,
    ST_WK_DAT,
    ST_WK_LOG,
    ST_WK_MUL,
    ST_POS,
    ST_PLOG,
    ST_PMUL,
    ST_BLOG,
    ST_DIV1,
    ST_DIV2,
    ST_OUT
  } back_state_t;

endpackage

// File: hdl/byte_window_entropy.sv
// Top level of the normalized Shannon byte entropy block.
// Bytes enter a four-item queue at most one per cycle while busy is low; the back end
// retires each byte through a queue pop, a histogram read and a histogram write, so
// busy rises when bursts fill the queue. After the last byte of a window the back end
// walks all 256 bins, reading and clearing each one and, for each nonzero bin, running
// the serial log2 unit and the shift-add multiplier; for a window of two or more bytes
// it then works out the window total term, the log of the bin span and the result by
// two serial divisions. The result is registered onto result as done is high for one
// cycle, and cannot be stalled by the receiver. After reset the 256 histogram bins
// are cleared, during which busy is high.
module byte_window_entropy import bwe_pkg::*; #(
  parameter int LOG2_MAX_LEN = 20,
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  in_item_t item,
  output logic     done,
  output result_t  result
);

  q_head_t head;
  logic    pop;
  logic    clearing;

  bwe_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .hold  (clearing),
    .pop   (pop),
    .head  (head),
    .busy  (busy)
  );

  bwe_back #(.LOG2_MAX_LEN(LOG2_MAX_LEN), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .result   (result),
    .done     (done)
  );

endmodule

// File: hdl/bwe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bwe_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/bwe_front.sv
// Front end: accepts items and holds them in a short queue for the back end.
module bwe_front import bwe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  in_item_t item,
  input  logic     hold,
  input  logic     pop,
  output q_head_t  head,
  output logic     busy
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  in_item_t       entries [DEPTH];
  logic [AW-1:0]  wptr;
  logic [AW-1:0]  rptr;
  logic [AW:0]    cnt;
  logic           push;

  // The queue refuses items when full or while the histogram is cleared.
  assign busy = hold | (cnt == (AW+1)'(DEPTH));
  assign push = start & ~busy;

  assign head.valid = (cnt != '0);
  assign head.item  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// File: hdl/bwe_log2.sv
// Iterative fixed-point log2: normalizes one bit a cycle, then squares once per fraction bit.
module bwe_log2 import bwe_pkg::*; #(
  parameter int XW = 21,
  parameter int FRAC_BITS = 16,
  localparam int EW = $clog2(XW),
  localparam int LW = EW + FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [XW-1:0] x,
  output logic [LW-1:0] y,
  output logic          done
);

  localparam int CW = $clog2(FRAC_BITS);

  logic                   run;
  logic                   sq_phase;
  logic [XW-1:0]          nrm;
  logic [EW-1:0]          e;
  logic [MANT_W-1:0]      m;
  logic [MANT_W-1:0]      mant;
  logic [FRAC_BITS-1:0]   frac;
  logic [CW-1:0]          cnt;
  logic [2*MANT_W-1:0]    prod;

  // The normalized value has its top bit at XW-1; take it as Q1.30.
  generate
    if (XW >= MANT_W) begin : g_trunc
      assign mant = nrm[XW-1 -: MANT_W];
    end else begin : g_pad
      assign mant = {nrm, {(MANT_W-XW){1'b0}}};
    end
  endgenerate

  assign prod = {{MANT_W{1'b0}}, m} * {{MANT_W{1'b0}}, m};
  assign y    = {e, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nrm      <= x;
        e        <= EW'(XW-1);
        sq_phase <= 1'b0;
        cnt      <= '0;
        frac     <= '0;
        run      <= 1'b1;
      end else if (run) begin
        if (!sq_phase) begin
          // Shift until the top bit is set; the shift count gives the exponent.
          if (nrm[XW-1] || (e == '0)) begin
            m        <= mant;
            sq_phase <= 1'b1;
          end else begin
            nrm <= nrm << 1;
            e   <= e - 1'b1;
          end
        end else begin
          // A square of two or more yields a one bit and is halved.
          if (prod[2*MANT_W-1]) begin
            m <= prod[2*MANT_W-1:MANT_W];
          end else begin
            m <= prod[2*MANT_W-2:MANT_W-1];
          end
          frac <= {frac[FRAC_BITS-2:0], prod[2*MANT_W-1]};
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(FRAC_BITS-1)) begin
            run  <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: hdl/bwe_mul.sv
// Shift-and-add multiplier that takes one multiplier bit a cycle.
module bwe_mul #(
  parameter int AW = 21,
  parameter int BW = 21
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p,
  output logic             done
);

  localparam int CW = $clog2(BW);

  logic             run;
  logic [AW+BW-1:0] mc;
  logic [BW-1:0]    mp;
  logic [CW-1:0]    cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        p   <= '0;
        mc  <= (AW+BW)'(a);
        mp  <= b;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (mp[0]) begin
          p <= p + mc;
        end
        mc  <= mc << 1;
        mp  <= mp >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(BW-1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/bwe_div.sv
// Restoring divider that produces one quotient bit a cycle.
module bwe_div #(
  parameter int NW = 58,
  parameter int VW = 21
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [NW-1:0] quot,
  output logic          done
);

  localparam int CW = $clog2(NW);

  logic          run;
  logic [VW-1:0] dv;
  logic [VW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [VW:0]   r2;
  logic          ge;

  assign r2 = {rem, quot[NW-1]};
  assign ge = (r2 >= {1'b0, dv});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= dividend;
        dv   <= divisor;
        rem  <= '0;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        // The dividend shifts out at the top while quotient bits enter below.
        if (ge) begin
          rem <= VW'(r2 - {1'b0, dv});
        end else begin
          rem <= r2[VW-1:0];
        end
        quot <= {quot[NW-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(NW-1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/bwe_back.sv
// Back end: histogram updates, the end-of-window entropy walk and the result register.
module bwe_back import bwe_pkg::*; #(
  parameter int LOG2_MAX_LEN = 20,
  parameter int FRAC_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  q_head_t head,
  output logic    pop,
  output logic    clearing,
  output result_t result,
  output logic    done
);

  localparam int CW = LOG2_MAX_LEN + 1;
  localparam int EW = $clog2(CW);
  localparam int LW = EW + FRAC_BITS;
  localparam int PW = CW + LW;
  localparam int NW = PW + Q_SHIFT;
  localparam int VW = (CW > LW) ? CW : LW;
  localparam logic [CW-1:0] MAX_LEN = {1'b1, {LOG2_MAX_LEN{1'b0}}};

  back_state_t state, state_next;

  in_item_t          cur;
  logic [BIN_W-1:0]  idx;
  logic [CW-1:0]     count;
  logic              too_long;
  logic [CW-1:0]     cval;
  logic [PW-1:0]     neg;
  logic [PW-1:0]     pos;
  logic [LW-1:0]     lb;
  logic [Q_W-1:0]    res_q;
  logic [1:0]        res_status;

  logic              ram_we;
  logic [BIN_W-1:0]  ram_waddr;
  logic [CW-1:0]     ram_wdata;
  logic [BIN_W-1:0]  ram_raddr;
  logic [CW-1:0]     ram_rdata;

  logic              log_start;
  logic [CW-1:0]     log_x;
  logic [LW-1:0]     log_y;
  logic              log_done;

  logic              mul_start;
  logic [CW-1:0]     mul_a;
  logic [PW-1:0]     mul_p;
  logic              mul_done;

  logic              div_start;
  logic [NW-1:0]     div_n;
  logic [VW-1:0]     div_d;
  logic [NW-1:0]     div_q;
  logic              div_done;

  logic              sat;
  logic [CW-1:0]     bval;
  logic [PW-1:0]     num;

  assign sat  = (count == MAX_LEN);
  assign bval = (count < CW'(NBINS)) ? count : CW'(NBINS);
  assign num  = (pos > neg) ? (pos - neg) : '0;

  bwe_ram #(.WIDTH(CW), .DEPTH(NBINS)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bwe_log2 #(.XW(CW), .FRAC_BITS(FRAC_BITS)) u_log (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .x     (log_x),
    .y     (log_y),
    .done  (log_done)
  );

  bwe_mul #(.AW(CW), .BW(LW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (log_y),
    .p     (mul_p),
    .done  (mul_done)
  );

  bwe_div #(.NW(NW), .VW(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quot     (div_q),
    .done     (div_done)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLR:    if (idx == '1) state_next = ST_IDLE;
      ST_IDLE:   if (head.valid) state_next = ST_RD;
      ST_RD:     state_next = ST_WR;
      ST_WR:     state_next = cur.last ? ST_WK_RD : ST_IDLE;
      ST_WK_RD:  state_next = ST_WK_DAT;
      ST_WK_DAT: begin
        if (ram_rdata != '0) begin
          state_next = ST_WK_LOG;
        end else if (idx == '1) begin
          state_next = ST_POS;
        end else begin
          state_next = ST_WK_RD;
        end
      end
      ST_WK_LOG: if (log_done) state_next = ST_WK_MUL;
      ST_WK_MUL: begin
        if (mul_done) begin
          state_next = (idx == '1) ? ST_POS : ST_WK_RD;
        end
      end
      ST_POS:    state_next = (count <= CW'(1)) ? ST_OUT : ST_PLOG;
      ST_PLOG:   if (log_done) state_next = ST_PMUL;
      ST_PMUL:   if (mul_done) state_next = ST_BLOG;
      ST_BLOG:   if (log_done) state_next = ST_DIV1;
      ST_DIV1:   if (div_done) state_next = ST_DIV2;
      ST_DIV2:   if (div_done) state_next = ST_OUT;
      ST_OUT:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    pop       = 1'b0;
    clearing  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    ram_raddr = idx;
    log_start = 1'b0;
    log_x     = count;
    mul_start = 1'b0;
    mul_a     = count;
    div_start = 1'b0;
    div_n     = NW'(num);
    div_d     = VW'(count);
    case (state)
      ST_CLR: begin
        clearing = 1'b1;
        ram_we   = 1'b1;
      end
      ST_IDLE:   pop = head.valid;
      ST_RD:     ram_raddr = cur.data_byte;
      ST_WR: begin
        ram_we    = ~sat;
        ram_waddr = cur.data_byte;
        ram_wdata = ram_rdata + 1'b1;
      end
      ST_WK_DAT: begin
        // Each bin is cleared as it is read.
        ram_we    = 1'b1;
        log_start = (ram_rdata != '0);
        log_x     = ram_rdata;
      end
      ST_WK_LOG: begin
        mul_start = log_done;
        mul_a     = cval;
      end
      ST_POS:    log_start = (count > CW'(1));
      ST_PLOG:   mul_start = log_done;
      ST_PMUL: begin
        log_start = mul_done;
        log_x     = bval;
      end
      ST_BLOG:   div_start = log_done;
      ST_DIV1: begin
        div_start = div_done;
        div_n     = {div_q[PW-1:0], {Q_SHIFT{1'b0}}} + NW'(lb >> 1);
        div_d     = VW'(lb);
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      idx      <= '0;
      count    <= '0;
      too_long <= 1'b0;
      neg      <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_OUT);
      case (state)
        ST_CLR:    idx <= idx + 1'b1;
        ST_WR: begin
          if (sat) begin
            too_long <= 1'b1;
          end else begin
            count <= count + 1'b1;
          end
        end
        ST_WK_DAT: if (ram_rdata == '0) idx <= idx + 1'b1;
        ST_WK_MUL: begin
          if (mul_done) begin
            neg <= neg + mul_p;
            idx <= idx + 1'b1;
          end
        end
        ST_OUT: begin
          count    <= '0;
          too_long <= 1'b0;
          neg      <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE:   if (head.valid) cur <= head.item;
      ST_WK_DAT: cval <= ram_rdata;
      ST_POS: begin
        res_q      <= '0;
        res_status <= STAT_SINGLE;
      end
      ST_PMUL:   if (mul_done) pos <= mul_p;
      ST_BLOG:   if (log_done) lb <= log_y;
      ST_DIV2: begin
        if (div_done) begin
          res_q      <= (div_q > NW'(Q_ONE)) ? Q_ONE : div_q[Q_W-1:0];
          res_status <= too_long ? STAT_LONG : STAT_OK;
        end
      end
      ST_OUT: begin
        result.entropy_q16 <= res_q;
        result.byte_count  <= CNT_OUT_W'(count);
        result.status      <= res_status;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: tb/sv/byte_window_entropy_test.sv
// Self-checking testbench for the byte window entropy block.
`timescale 1ns / 100ps

module byte_window_entropy_test;
  import bwe_pkg::*;

  localparam int LOG2_MAX_LEN = 20;
  localparam int FRAC_BITS    = 16;
  localparam longint unsigned MAX_LEN = 64'd1 << LOG2_MAX_LEN;
  localparam longint unsigned CYCLE_LIMIT = 64'd9000000;
  // Idle cycles after the last expected result, to catch a stray one.
  localparam int DRAIN_CYCLES = 400;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  in_item_t item;
  logic     done;
  result_t  result;

  // Shadow of the block state used for prediction.
  longint unsigned bin_count[NBINS];
  longint unsigned win_len;
  bit              win_overflow;

  result_t expected_results[$];
  bit      failed;
  longint unsigned cycle_count;

  // Sender pacing: bursts of random length split by random gaps.
  int burst_left;
  bit no_gaps;

  byte_window_entropy #(
    .LOG2_MAX_LEN(LOG2_MAX_LEN),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Fixed-point log2 with FRAC_BITS fraction bits, mantissa kept in Q1.30.
  function automatic longint unsigned log2_fixed(longint unsigned x);
    int unsigned top;
    longint unsigned mant;
    longint unsigned frac;
    top = 0;
    frac = 0;
    if (x == 0) begin
      return 0;
    end
    while (top < 63 && (x >> (top + 1)) != 0) begin
      top++;
    end
    if (top <= 30) begin
      mant = x << (30 - top);
    end else begin
      mant = x >> (top - 30);
    end
    for (int i = 0; i < FRAC_BITS; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd2 << 30)) begin
        frac = frac | 64'd1;
        mant = mant >> 1;
      end
    end
    return (longint'(top) << FRAC_BITS) | frac;
  endfunction

  // Normalized entropy of the shadow histogram, as the block reports it.
  function automatic result_t window_entropy();
    result_t r;
    longint unsigned span;
    longint unsigned log_span;
    longint unsigned total_term;
    longint unsigned bin_terms;
    longint unsigned numer;
    longint unsigned bits;
    longint unsigned norm;
    r.byte_count = win_len[20:0];
    if (win_len <= 1) begin
      r.entropy_q16 = '0;
      r.status = STAT_SINGLE;
      return r;
    end
    span = (win_len < NBINS) ? win_len : NBINS;
    log_span = log2_fixed(span);
    total_term = win_len * log2_fixed(win_len);
    bin_terms = 0;
    for (int i = 0; i < NBINS; i++) begin
      if (bin_count[i] != 0) begin
        bin_terms += bin_count[i] * log2_fixed(bin_count[i]);
      end
    end
    numer = (total_term > bin_terms) ? total_term - bin_terms : 0;
    bits = numer / win_len;
    norm = (log_span != 0) ? ((bits << 16) + log_span / 2) / log_span : 0;
    if (norm > 65536) begin
      norm = 65536;
    end
    r.entropy_q16 = norm[16:0];
    r.status = win_overflow ? STAT_LONG : STAT_OK;
    return r;
  endfunction

  function automatic void clear_shadow();
    foreach (bin_count[i]) begin
      bin_count[i] = 0;
    end
    win_len = 0;
    win_overflow = 1'b0;
  endfunction

  // Update the shadow with one accepted byte; queue a result on a last byte.
  function automatic void absorb_byte(logic [7:0] b, logic is_last);
    if (win_len < MAX_LEN) begin
      win_len++;
      bin_count[b]++;
    end else begin
      win_overflow = 1'b1;
    end
    if (is_last) begin
      expected_results.push_back(window_entropy());
      clear_shadow();
    end
  endfunction

  // Offer one item and hold it until the block takes it, then maybe idle.
  task automatic send_byte(logic [7:0] b, logic is_last);
    start <= 1'b1;
    item.data_byte <= b;
    item.last <= is_last;
    do begin
      @(posedge clk);
    end while (busy);
    absorb_byte(b, is_last);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Check every result against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d", $time,
                 result.entropy_q16, result.byte_count, result.status);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (result.entropy_q16 !== want.entropy_q16) begin
          $display("%0t: entropy_q16 expected %0d actual %0d", $time,
                   want.entropy_q16, result.entropy_q16);
          failed = 1'b1;
        end
        if (result.byte_count !== want.byte_count) begin
          $display("%0t: byte_count expected %0d actual %0d", $time,
                   want.byte_count, result.byte_count);
          failed = 1'b1;
        end
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, result.status);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Single-byte windows at both ends of the byte range.
  task automatic test_single_byte();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // Lowest and highest entropy windows and a small odd size.
  task automatic test_extremes();
    send_byte(8'hAA, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    for (int i = 0; i < NBINS; i++) begin
      send_byte(i[7:0], i == NBINS - 1);
    end
  endtask

  // Let every outstanding window finish before sending more.
  task automatic test_pause_drain();
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h12, 1'b1);
    wait_drained();
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  // Random windows, mostly short, with random or narrow alphabets.
  task automatic test_random_windows();
    int sent;
    int len;
    int alphabet;
    logic [7:0] base;
    sent = 0;
    while (sent < 1200) begin
      case ($urandom_range(0, 19))
        0: len = 1;
        1: len = $urandom_range(257, 400);
        2, 3: len = $urandom_range(20, 120);
        default: len = $urandom_range(2, 16);
      endcase
      alphabet = ($urandom_range(0, 1) != 0) ? 256 : $urandom_range(1, 8);
      base = 8'($urandom);
      no_gaps = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
        send_byte(base + 8'($urandom_range(0, alphabet - 1)), i == len - 1);
      end
      sent += len;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    failed = 1'b0;
    cycle_count = 0;
    burst_left = 4;
    no_gaps = 1'b0;
    clear_shadow();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_single_byte();
    test_extremes();
    test_pause_drain();
    test_random_windows();
    start <= 1'b0;
    wait_drained();
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
